[rtl/tcpop_pkg.sv]
`timescale 1ns / 1ps

package tcpop_pkg;

  // option kinds
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACKOK = 8'd4;
  localparam logic [7:0] KIND_TSTAMP = 8'd8;

  // fixed lengths of known kinds
  localparam logic [7:0] LEN_MSS     = 8'd4;
  localparam logic [7:0] LEN_WSCALE  = 8'd3;
  localparam logic [7:0] LEN_TSTAMP  = 8'd10;
  localparam logic [7:0] LEN_SACKOK  = 8'd2;
  localparam logic [7:0] LEN_MIN     = 8'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_NOP      = 3'd2;
  localparam logic [2:0] ST_EOL      = 3'd3;
  localparam logic [2:0] ST_BADLEN   = 3'd4;
  localparam logic [2:0] ST_BADKNOWN = 3'd5;
  localparam logic [2:0] ST_AREA_END = 3'd6;

  typedef enum logic [3:0] {
    PH_KIND = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  opt_kind;
    logic [2:0]  status;
    logic [7:0]  opt_length;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] scale_multiplier;
    logic        area_end;
  } result_t;

endpackage

[rtl/tcp_option_parser.sv]
`timescale 1ns / 1ps

// TCP option area parser. Feed the bytes of one option area in order, one per
// transaction, with in_last_byte set on the final byte. Each option is reported
// on the transaction that completes it (NOP, end of list, or a full option with
// MSS, window scale and multiplier, SACK permitted or timestamp decoded and
// length-checked; other kinds come back as unknown with their length). After
// end of list or a length below two the rest of the area is ignored. The final
// byte always yields a result with out_area_end set, which reports a cut-off
// option as area ended; the parser is then clean for the next area. One byte is
// accepted every cycle while out_ready stays high: the parse state updates from the
// incoming byte, and the result sits in one output register that is refilled
// in the same cycle it is taken, so each result is valid in the cycle after the
// byte that completes it is accepted.
module tcp_option_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_opt_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_opt_kind,
  output logic [2:0]  out_status,
  output logic [7:0]  out_opt_length,
  output logic [31:0] out_value_a,
  output logic [31:0] out_value_b,
  output logic [31:0] out_scale_multiplier,
  output logic        out_area_end
);

  tcpop_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]         kind_r, kind_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [31:0]        acc_a_r, acc_a_nxt;
  logic [31:0]        acc_b_r, acc_b_nxt;

  logic               out_valid_r;
  tcpop_pkg::result_t res_r;
  tcpop_pkg::result_t res;
  logic               have;
  logic               fin;
  logic               in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    have      = 1'b0;
    fin       = 1'b0;
    res       = '0;

    unique case (phase_r)
      tcpop_pkg::PH_KIND: begin
        if (in_opt_byte == tcpop_pkg::KIND_EOL) begin
          have         = 1'b1;
          res.opt_kind = tcpop_pkg::KIND_EOL;
          res.status   = tcpop_pkg::ST_EOL;
          phase_nxt    = tcpop_pkg::PH_DONE;
        end else if (in_opt_byte == tcpop_pkg::KIND_NOP) begin
          have         = 1'b1;
          res.opt_kind = tcpop_pkg::KIND_NOP;
          res.status   = tcpop_pkg::ST_NOP;
        end else begin
          kind_nxt  = in_opt_byte;
          phase_nxt = tcpop_pkg::PH_LEN;
        end
      end
      tcpop_pkg::PH_LEN: begin
        len_nxt = in_opt_byte;
        if (in_opt_byte < tcpop_pkg::LEN_MIN) begin
          have           = 1'b1;
          res.opt_kind   = kind_r;
          res.status     = tcpop_pkg::ST_BADLEN;
          res.opt_length = in_opt_byte;
          phase_nxt      = tcpop_pkg::PH_DONE;
        end else begin
          cnt_nxt   = '0;
          acc_a_nxt = '0;
          acc_b_nxt = '0;
          if (in_opt_byte == tcpop_pkg::LEN_MIN) begin
            fin       = 1'b1;
            phase_nxt = tcpop_pkg::PH_KIND;
          end else begin
            phase_nxt = tcpop_pkg::PH_BODY;
          end
        end
      end
      tcpop_pkg::PH_BODY: begin
        // first four body bytes into the first word, next four into the second
        if (cnt_r < 8'd4) begin
          acc_a_nxt = {acc_a_r[23:0], in_opt_byte};
        end else if (cnt_r < 8'd8) begin
          acc_b_nxt = {acc_b_r[23:0], in_opt_byte};
        end
        cnt_nxt = cnt_r + 8'd1;
        if ({1'b0, cnt_nxt} + 9'd2 == {1'b0, len_r}) begin
          fin       = 1'b1;
          phase_nxt = tcpop_pkg::PH_KIND;
        end
      end
      tcpop_pkg::PH_DONE: begin
      end
      default: begin
        phase_nxt = tcpop_pkg::PH_DONE;
      end
    endcase

    if (fin) begin
      have           = 1'b1;
      res.opt_kind   = kind_nxt;
      res.opt_length = len_nxt;
      res.status     = tcpop_pkg::ST_OK;
      case (kind_nxt)
        tcpop_pkg::KIND_MSS: begin
          if (len_nxt == tcpop_pkg::LEN_MSS) begin
            res.value_a = {16'd0, acc_a_nxt[15:0]};
          end else begin
            res.status = tcpop_pkg::ST_BADKNOWN;
          end
        end
        tcpop_pkg::KIND_WSCALE: begin
          if (len_nxt == tcpop_pkg::LEN_WSCALE) begin
            res.value_a = {24'd0, acc_a_nxt[7:0]};
            if (acc_a_nxt[7:5] == 3'd0) begin
              res.scale_multiplier = 32'd1 << acc_a_nxt[4:0];
            end
          end else begin
            res.status = tcpop_pkg::ST_BADKNOWN;
          end
        end
        tcpop_pkg::KIND_SACKOK: begin
          if (len_nxt != tcpop_pkg::LEN_SACKOK) begin
            res.status = tcpop_pkg::ST_BADKNOWN;
          end
        end
        tcpop_pkg::KIND_TSTAMP: begin
          if (len_nxt == tcpop_pkg::LEN_TSTAMP) begin
            res.value_a = acc_a_nxt;
            res.value_b = acc_b_nxt;
          end else begin
            res.status = tcpop_pkg::ST_BADKNOWN;
          end
        end
        default: begin
          res.status = tcpop_pkg::ST_UNKNOWN;
        end
      endcase
    end

    if (in_last_byte) begin
      if (!have) begin
        have       = 1'b1;
        res        = '0;
        res.status = tcpop_pkg::ST_AREA_END;
        if (phase_nxt == tcpop_pkg::PH_LEN) begin
          res.opt_kind = kind_nxt;
        end else if (phase_nxt == tcpop_pkg::PH_BODY) begin
          res.opt_kind   = kind_nxt;
          res.opt_length = len_nxt;
        end
      end
      res.area_end = 1'b1;
      // start the next area clean
      phase_nxt = tcpop_pkg::PH_KIND;
      kind_nxt  = '0;
      len_nxt   = '0;
      cnt_nxt   = '0;
      acc_a_nxt = '0;
      acc_b_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tcpop_pkg::PH_KIND;
      kind_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= have;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the payload until a new result replaces it
  always_ff @(posedge clk) begin
    if (in_fire && have) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_opt_kind         = res_r.opt_kind;
  assign out_status           = res_r.status;
  assign out_opt_length       = res_r.opt_length;
  assign out_value_a          = res_r.value_a;
  assign out_value_b          = res_r.value_b;
  assign out_scale_multiplier = res_r.scale_multiplier;
  assign out_area_end         = res_r.area_end;

`ifndef NO_ASSERTIONS
  a_last_gives_area_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> out_valid_r && res_r.area_end)
    else $error("last byte did not produce an area end result");

  a_last_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> phase_r == tcpop_pkg::PH_KIND)
    else $error("parse phase not back to kind after area end");

  a_body_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tcpop_pkg::PH_BODY |-> {1'b0, cnt_r} + 9'd2 < {1'b0, len_r})
    else $error("body count ran past declared length");

  a_values_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status != tcpop_pkg::ST_OK
      |-> res_r.value_a == 32'd0 && res_r.value_b == 32'd0
          && res_r.scale_multiplier == 32'd0)
    else $error("nonzero values on a failed option");

  a_multiplier_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.opt_kind == tcpop_pkg::KIND_WSCALE
      && res_r.status == tcpop_pkg::ST_OK && res_r.value_a[7:5] == 3'd0
      |-> $onehot(res_r.scale_multiplier))
    else $error("window scale multiplier not a single bit");
`endif

endmodule

[verif/tcp_option_parser_tb.sv]
`timescale 1ns / 1ps

module tcp_option_parser_tb;

  localparam int IDLE_LIMIT  = 1000;
  localparam int TARGET_BYTES = 1400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_opt_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_opt_kind;
  logic [2:0]  out_status;
  logic [7:0]  out_opt_length;
  logic [31:0] out_value_a;
  logic [31:0] out_value_b;
  logic [31:0] out_scale_multiplier;
  logic        out_area_end;

  tcp_option_parser u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opt_byte          (in_opt_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_opt_kind         (out_opt_kind),
    .out_status           (out_status),
    .out_opt_length       (out_opt_length),
    .out_value_a          (out_value_a),
    .out_value_b          (out_value_b),
    .out_scale_multiplier (out_scale_multiplier),
    .out_area_end         (out_area_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser shadow state
  tcpop_pkg::phase_t ph;
  logic [7:0]  cur_kind;
  logic [7:0]  decl_len;
  logic [7:0]  body_cnt;
  logic [31:0] word_a;
  logic [31:0] word_b;

  tcpop_pkg::result_t pending_results[$];
  logic [7:0]  area_q[$];

  int errors = 0;
  int bytes_sent = 0;
  int areas_sent = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  bit quiet_in = 1'b0;

  task automatic clear_parser();
    ph       = tcpop_pkg::PH_KIND;
    cur_kind = '0;
    decl_len = '0;
    body_cnt = '0;
    word_a   = '0;
    word_b   = '0;
  endtask

  function automatic tcpop_pkg::result_t option_result();
    tcpop_pkg::result_t r;
    logic [7:0] sc;
    r = '0;
    r.opt_kind   = cur_kind;
    r.opt_length = decl_len;
    r.status     = tcpop_pkg::ST_OK;
    sc = word_a[7:0];
    case (cur_kind)
      tcpop_pkg::KIND_MSS: begin
        if (decl_len == tcpop_pkg::LEN_MSS) r.value_a = {16'd0, word_a[15:0]};
        else r.status = tcpop_pkg::ST_BADKNOWN;
      end
      tcpop_pkg::KIND_WSCALE: begin
        if (decl_len == tcpop_pkg::LEN_WSCALE) begin
          r.value_a = {24'd0, sc};
          r.scale_multiplier = (sc <= 8'd31) ? (32'd1 << sc) : 32'd0;
        end else begin
          r.status = tcpop_pkg::ST_BADKNOWN;
        end
      end
      tcpop_pkg::KIND_SACKOK: begin
        if (decl_len != tcpop_pkg::LEN_SACKOK) r.status = tcpop_pkg::ST_BADKNOWN;
      end
      tcpop_pkg::KIND_TSTAMP: begin
        if (decl_len == tcpop_pkg::LEN_TSTAMP) begin
          r.value_a = word_a;
          r.value_b = word_b;
        end else begin
          r.status = tcpop_pkg::ST_BADKNOWN;
        end
      end
      default: r.status = tcpop_pkg::ST_UNKNOWN;
    endcase
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last,
                              output bit have, output tcpop_pkg::result_t r);
    have = 1'b0;
    r = '0;
    case (ph)
      tcpop_pkg::PH_KIND: begin
        if (b == tcpop_pkg::KIND_EOL) begin
          r.opt_kind = tcpop_pkg::KIND_EOL;
          r.status   = tcpop_pkg::ST_EOL;
          have = 1'b1;
          ph = tcpop_pkg::PH_DONE;
        end else if (b == tcpop_pkg::KIND_NOP) begin
          r.opt_kind = tcpop_pkg::KIND_NOP;
          r.status   = tcpop_pkg::ST_NOP;
          have = 1'b1;
        end else begin
          cur_kind = b;
          ph = tcpop_pkg::PH_LEN;
        end
      end
      tcpop_pkg::PH_LEN: begin
        decl_len = b;
        if (b < tcpop_pkg::LEN_MIN) begin
          r.opt_kind   = cur_kind;
          r.status     = tcpop_pkg::ST_BADLEN;
          r.opt_length = b;
          have = 1'b1;
          ph = tcpop_pkg::PH_DONE;
        end else begin
          body_cnt = '0;
          word_a   = '0;
          word_b   = '0;
          if (b == tcpop_pkg::LEN_MIN) begin
            r = option_result();
            have = 1'b1;
            ph = tcpop_pkg::PH_KIND;
          end else begin
            ph = tcpop_pkg::PH_BODY;
          end
        end
      end
      tcpop_pkg::PH_BODY: begin
        if (body_cnt < 8'd4) word_a = {word_a[23:0], b};
        else if (body_cnt < 8'd8) word_b = {word_b[23:0], b};
        body_cnt = body_cnt + 8'd1;
        if ({1'b0, body_cnt} + 9'd2 == {1'b0, decl_len}) begin
          r = option_result();
          have = 1'b1;
          ph = tcpop_pkg::PH_KIND;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (!have) begin
        // report whatever option was cut off by the area end
        r = '0;
        r.status = tcpop_pkg::ST_AREA_END;
        if (ph == tcpop_pkg::PH_LEN) begin
          r.opt_kind = cur_kind;
        end else if (ph == tcpop_pkg::PH_BODY) begin
          r.opt_kind   = cur_kind;
          r.opt_length = decl_len;
        end
        have = 1'b1;
      end
      r.area_end = 1'b1;
      clear_parser();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_in || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one byte; in_valid stays high when the next one follows at once
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    bit have;
    tcpop_pkg::result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opt_byte  <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    predict_byte(b, last, have, r);
    if (have) pending_results.push_back(r);
  endtask

  task automatic send_area();
    for (int i = 0; i < area_q.size(); i++)
      send_byte(area_q[i], i == area_q.size() - 1);
    areas_sent++;
  endtask

  // hold the input until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_noise(input int n);
    repeat (n) area_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_option(input logic [7:0] kind, input logic [7:0] len);
    area_q.push_back(kind);
    area_q.push_back(len);
    if (kind == tcpop_pkg::KIND_WSCALE && len == tcpop_pkg::LEN_WSCALE) begin
      area_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                             : 8'($urandom_range(0, 255)));
    end else if (len > tcpop_pkg::LEN_MIN) begin
      add_noise(int'(len) - 2);
    end
  endtask

  function automatic logic [7:0] known_len(input logic [7:0] proper);
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(2, 12));
    return proper;
  endfunction

  task automatic build_random_area();
    int n_opts;
    int sel;
    int cut;
    bit stop;
    area_q.delete();
    n_opts = $urandom_range(1, 8);
    stop = 1'b0;
    for (int i = 0; i < n_opts && !stop; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        area_q.push_back(tcpop_pkg::KIND_NOP);
      end else if (sel < 17) begin
        area_q.push_back(tcpop_pkg::KIND_EOL);
        add_noise($urandom_range(0, 3));
        stop = 1'b1;
      end else if (sel < 30) begin
        push_option(tcpop_pkg::KIND_MSS, known_len(tcpop_pkg::LEN_MSS));
      end else if (sel < 42) begin
        push_option(tcpop_pkg::KIND_WSCALE, known_len(tcpop_pkg::LEN_WSCALE));
      end else if (sel < 52) begin
        push_option(tcpop_pkg::KIND_SACKOK, known_len(tcpop_pkg::LEN_SACKOK));
      end else if (sel < 72) begin
        push_option(tcpop_pkg::KIND_TSTAMP, known_len(tcpop_pkg::LEN_TSTAMP));
      end else if (sel < 77) begin
        // length below two ends parsing for the rest of the area
        area_q.push_back(8'($urandom_range(2, 255)));
        area_q.push_back(8'($urandom_range(0, 1)));
        add_noise($urandom_range(0, 3));
        stop = 1'b1;
      end else begin
        push_option(8'($urandom_range(5, 255)),
                    ($urandom_range(0, 49) == 0) ? 8'd255 : 8'($urandom_range(2, 12)));
      end
    end
    // cut some areas short so options end truncated
    if ($urandom_range(0, 4) == 0 && area_q.size() > 1) begin
      cut = $urandom_range(1, area_q.size() - 1);
      repeat (cut) void'(area_q.pop_back());
    end
  endtask

  task automatic test_option_kinds();
    // nop, max mss, end of list, then an ignored byte that closes the area
    area_q = '{tcpop_pkg::KIND_NOP, tcpop_pkg::KIND_MSS, tcpop_pkg::LEN_MSS,
               8'hFF, 8'hFF, tcpop_pkg::KIND_EOL, 8'hAA};
    send_area();
    // timestamp ending on the area's last byte
    area_q = '{tcpop_pkg::KIND_TSTAMP, tcpop_pkg::LEN_TSTAMP, 8'h80, 8'h01, 8'hFE,
               8'h7F, 8'hFF, 8'h00, 8'h55, 8'hAA};
    send_area();
    // scale too large, then sack permitted completing on its length byte
    area_q = '{tcpop_pkg::KIND_WSCALE, tcpop_pkg::LEN_WSCALE, 8'd32,
               tcpop_pkg::KIND_SACKOK, tcpop_pkg::LEN_SACKOK};
    send_area();
    drain_results();
  endtask

  task automatic test_area_end_cases();
    area_q = '{8'hFF, 8'h01, 8'h7E};
    send_area();
    area_q = '{tcpop_pkg::KIND_MSS, tcpop_pkg::LEN_MSS, 8'h01};
    send_area();
    area_q = '{8'h80};
    send_area();
    drain_results();
  endtask

  task automatic test_noise_bytes();
    repeat (10) begin
      area_q.delete();
      add_noise($urandom_range(1, 16));
      send_area();
    end
  endtask

  task automatic test_random_areas();
    int n;
    n = 0;
    while (bytes_sent < TARGET_BYTES) begin
      quiet_in = ($urandom_range(0, 5) == 0);
      build_random_area();
      send_area();
      n++;
      if (n % 25 == 0) drain_results();
    end
    quiet_in = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h",
             results_checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    tcpop_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", {24'd0, out_opt_kind}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_opt_kind !== want.opt_kind)
          report_mismatch("opt_kind", {24'd0, out_opt_kind}, {24'd0, want.opt_kind});
        if (out_status !== want.status)
          report_mismatch("status", {29'd0, out_status}, {29'd0, want.status});
        if (out_opt_length !== want.opt_length)
          report_mismatch("opt_length", {24'd0, out_opt_length}, {24'd0, want.opt_length});
        if (out_value_a !== want.value_a)
          report_mismatch("value_a", out_value_a, want.value_a);
        if (out_value_b !== want.value_b)
          report_mismatch("value_b", out_value_b, want.value_b);
        if (out_scale_multiplier !== want.scale_multiplier)
          report_mismatch("scale_multiplier", out_scale_multiplier, want.scale_multiplier);
        if (out_area_end !== want.area_end)
          report_mismatch("area_end", {31'd0, out_area_end}, {31'd0, want.area_end});
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("[tcp_option_parser] ERROR");
        $finish;
      end
    end
  end

  // result side back-pressure: runs of ready broken by stalls
  initial begin : drive_out_ready
    int run;
    int stall;
    int r;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) run = $urandom_range(50, 200);
      else run = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 70) stall = $urandom_range(1, 3);
      else if (r < 95) stall = $urandom_range(4, 8);
      else stall = $urandom_range(20, 60);
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  initial begin
    clear_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_option_kinds();
    test_area_end_cases();
    test_noise_bytes();
    test_random_areas();
    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d option bytes in %0d areas, %0d results compared",
             bytes_sent, areas_sent, results_checked);
    $display("mix: known, unknown, truncated and malformed options with random stalls");
    if (errors == 0) $display("[tcp_option_parser] OK");
    else $display("[tcp_option_parser] ERROR");
    $finish;
  end

endmodule
